[sv/tvtc_pkg.sv]
`default_nettype none
package tvtc_pkg;

    localparam int SEC_W  = 64;
    localparam int USEC_W = 21;
    localparam int CFG_W  = 20;
    localparam int TICK_W = 31;
    localparam int NUM_W  = 64;
    localparam int HALF_W = 22;              // seconds split for the partial products
    localparam int SECA_W = 2 * HALF_W;      // seconds bits that reach the multiplier
    localparam int PP_W   = HALF_W + CFG_W;  // width of one partial product
    localparam int QUO_W  = TICK_W;          // quotient bits out of the divider

    localparam logic [CFG_W-1:0]  USEC_PER_SEC    = 20'd1000000;
    // largest seconds value whose microsecond total still fits a signed 64-bit value
    localparam logic [SECA_W-1:0] SEC_LIMIT       = 44'd9223372036854;
    localparam logic [CFG_W-1:0]  TICK_LEN_RESET  = 20'd1000;
    localparam logic [CFG_W-1:0]  TICK_RATE_RESET = 20'd1000;
    localparam logic [TICK_W-1:0] TICK_MAX        = '1;
    localparam logic [TICK_W-1:0] TICK_ONE        = 31'd1;

    typedef enum logic {
        REG_TICK_LEN  = 1'b0,
        REG_TICK_RATE = 1'b1
    } reg_idx_t;

    // side information that rides with the dividend
    typedef struct packed {
        logic valid;
        logic neg;
        logic sat;
    } tvtc_flags_t;

endpackage
`default_nettype wire

[sv/tvtc_div.sv]
`default_nettype none
module tvtc_div (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   en,
    input  wire  [tvtc_pkg::CFG_W-1:0]            tick_len,
    input  wire  tvtc_pkg::tvtc_flags_t           in_flags,
    input  wire  [tvtc_pkg::NUM_W-1:0]            num,
    output logic                                  out_valid,
    output logic [tvtc_pkg::TICK_W-1:0]           out_ticks
);

    localparam int STEPS = tvtc_pkg::QUO_W;

    logic                               vld_reg [STEPS+1];
    logic                               neg_reg [STEPS+1];
    logic                               sat_reg [STEPS+1];
    logic [tvtc_pkg::CFG_W-1:0]         rem_reg [STEPS+1];
    logic [tvtc_pkg::QUO_W-1:0]         low_reg [STEPS+1];
    logic [tvtc_pkg::QUO_W-1:0]         quo_reg [STEPS+1];

    logic                               ovld_reg;
    logic [tvtc_pkg::TICK_W-1:0]        otick_reg;
    logic                               sat_next;
    logic [tvtc_pkg::TICK_W-1:0]        otick_next;

    // quotient would need more than 31 bits: saturate
    assign sat_next = in_flags.sat ||
        (num[tvtc_pkg::NUM_W-1:tvtc_pkg::QUO_W] >=
         {{(tvtc_pkg::NUM_W-tvtc_pkg::QUO_W-tvtc_pkg::CFG_W){1'b0}}, tick_len});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_flags.valid;
        end
        if (en) begin
            neg_reg[0] <= in_flags.neg;
            sat_reg[0] <= sat_next;
            rem_reg[0] <= num[tvtc_pkg::QUO_W +: tvtc_pkg::CFG_W];
            low_reg[0] <= num[tvtc_pkg::QUO_W-1:0];
            quo_reg[0] <= '0;
        end
    end

    // one restoring step per stage, msb first
    for (genvar j = 0; j < STEPS; j++) begin : g_step
        logic [tvtc_pkg::CFG_W:0]   trial;
        logic                       fits;
        logic [tvtc_pkg::CFG_W:0]   diff;

        assign trial = {rem_reg[j], low_reg[j][STEPS-1-j]};
        assign fits  = (trial >= {1'b0, tick_len});
        assign diff  = trial - {1'b0, tick_len};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                vld_reg[j+1] <= vld_reg[j];
            end
            if (en) begin
                neg_reg[j+1] <= neg_reg[j];
                sat_reg[j+1] <= sat_reg[j];
                low_reg[j+1] <= low_reg[j];
                rem_reg[j+1] <= fits ? diff[tvtc_pkg::CFG_W-1:0]
                                     : trial[tvtc_pkg::CFG_W-1:0];
                quo_reg[j+1] <= {quo_reg[j][tvtc_pkg::QUO_W-2:0], fits};
            end
        end
    end

    always_comb begin
        if (neg_reg[STEPS]) begin
            otick_next = tvtc_pkg::TICK_ONE;
        end else if (sat_reg[STEPS] || (quo_reg[STEPS] == tvtc_pkg::TICK_MAX)) begin
            otick_next = tvtc_pkg::TICK_MAX;
        end else begin
            otick_next = quo_reg[STEPS] + tvtc_pkg::TICK_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovld_reg <= 1'b0;
        end else if (en) begin
            ovld_reg <= vld_reg[STEPS];
        end
        if (en) begin
            otick_reg <= otick_next;
        end
    end

    assign out_valid = ovld_reg;
    assign out_ticks = otick_reg;

`ifndef NO_ASSERTIONS
    // partial remainder must stay below the divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[STEPS] && !sat_reg[STEPS]) |-> (rem_reg[STEPS] < tick_len))
        else $error("divider remainder out of range");

    // a negative interval always yields one tick
    a_neg_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && vld_reg[STEPS] && neg_reg[STEPS]) |=> (otick_reg == tvtc_pkg::TICK_ONE))
        else $error("negative interval not mapped to one tick");
`endif

endmodule
`default_nettype wire

[sv/time_interval_to_tick_count.sv]
`default_nettype none
// Pipeline from an accepted s_ beat to its m_ beat: 4 front stages,
//   a divider operand register plus 31 restoring steps at one quotient bit each,
//   1 output stage.
// Throughput: one beat per cycle; the whole pipe advances whenever the output
//   register is empty or being taken, so a stall holds every stage in place.
// Reset: aresetn is synchronous, active low; clears all stage valids and loads
//   tick_length_us = 1000, ticks_per_second = 1000.
module time_interval_to_tick_count (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [87:0] s_tdata,    // [63:0] seconds, [84:64] microseconds, rest zero

    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,    // [30:0] tick_count, [31] zero

    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- configuration registers ----------------
    logic [tvtc_pkg::CFG_W-1:0] tick_len_reg;
    logic [tvtc_pkg::CFG_W-1:0] tick_rate_reg;
    logic [tvtc_pkg::CFG_W-1:0] tk_eff;
    logic [tvtc_pkg::CFG_W-1:0] tk_m1;
    logic                       cfg_wr;
    tvtc_pkg::reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = tvtc_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_len_reg  <= tvtc_pkg::TICK_LEN_RESET;
            tick_rate_reg <= tvtc_pkg::TICK_RATE_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                tvtc_pkg::REG_TICK_LEN:  tick_len_reg  <= pwdata[tvtc_pkg::CFG_W-1:0];
                tvtc_pkg::REG_TICK_RATE: tick_rate_reg <= pwdata[tvtc_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            tvtc_pkg::REG_TICK_LEN:  prdata = {12'b0, tick_len_reg};
            tvtc_pkg::REG_TICK_RATE: prdata = {12'b0, tick_rate_reg};
            default:                 prdata = '0;
        endcase
    end

    // zero tick length behaves as one
    assign tk_eff = (tick_len_reg == '0) ? 20'd1 : tick_len_reg;
    assign tk_m1  = tk_eff - 20'd1;

    // Note: the rate register never reaches the datapath. Seconds beyond
    // SEC_LIMIT give at least SEC_LIMIT ticks for any rate, far above the
    // 31-bit clamp, so every such item saturates.

    // ---------------- pipeline control ----------------
    logic en;
    logic div_valid;
    logic [tvtc_pkg::TICK_W-1:0] div_ticks;

    assign en       = !div_valid || m_tready;
    assign s_tready = en;
    assign m_tvalid = div_valid;
    assign m_tdata  = {1'b0, div_ticks};

    // ---------------- stage 1: borrow, sign, microsecond part ----------------
    logic signed [tvtc_pkg::SEC_W-1:0]  sec_in;
    logic signed [tvtc_pkg::USEC_W-1:0] usec_in;
    logic                               usec_neg;
    logic        [tvtc_pkg::USEC_W:0]   usec_sum;
    logic        [tvtc_pkg::USEC_W-1:0] u_next;
    logic        [tvtc_pkg::SEC_W-1:0]  sec_next;
    logic                               neg_next;

    assign sec_in   = s_tdata[63:0];
    assign usec_in  = s_tdata[84:64];
    assign usec_neg = usec_in[tvtc_pkg::USEC_W-1];
    assign usec_sum = {usec_in[tvtc_pkg::USEC_W-1], usec_in} + {2'b0, tvtc_pkg::USEC_PER_SEC};
    assign sec_next = sec_in - {{(tvtc_pkg::SEC_W-1){1'b0}}, usec_neg};
    // negative input, or zero seconds borrowing into minus one
    assign neg_next = sec_in[tvtc_pkg::SEC_W-1] || ((sec_in == '0) && usec_neg);

    always_comb begin
        if (!usec_neg) begin
            u_next = usec_in;
        end else if (usec_sum[tvtc_pkg::USEC_W]) begin
            u_next = '0;                            // still negative after borrow
        end else begin
            u_next = usec_sum[tvtc_pkg::USEC_W-1:0];
        end
    end

    logic                        s1_vld_reg;
    logic                        s1_neg_reg;
    logic [tvtc_pkg::SEC_W-1:0]  s1_sec_reg;
    logic [tvtc_pkg::USEC_W-1:0] s1_u_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_tvalid;
        end
        if (en) begin
            s1_neg_reg <= neg_next;
            s1_sec_reg <= sec_next;
            s1_u_reg   <= u_next;
        end
    end

    // ---------------- stage 2: range check, partial products ----------------
    logic                        big_next;
    logic [tvtc_pkg::PP_W-1:0]   pl_next;
    logic [tvtc_pkg::PP_W-1:0]   ph_next;

    assign big_next = (s1_sec_reg[tvtc_pkg::SEC_W-1:tvtc_pkg::SECA_W] != '0) ||
                      (s1_sec_reg[tvtc_pkg::SECA_W-1:0] > tvtc_pkg::SEC_LIMIT);
    assign pl_next  = {{tvtc_pkg::CFG_W{1'b0}}, s1_sec_reg[tvtc_pkg::HALF_W-1:0]} *
                      {{tvtc_pkg::HALF_W{1'b0}}, tvtc_pkg::USEC_PER_SEC};
    assign ph_next  = {{tvtc_pkg::CFG_W{1'b0}},
                       s1_sec_reg[tvtc_pkg::SECA_W-1:tvtc_pkg::HALF_W]} *
                      {{tvtc_pkg::HALF_W{1'b0}}, tvtc_pkg::USEC_PER_SEC};

    logic                        s2_vld_reg;
    logic                        s2_neg_reg;
    logic                        s2_big_reg;
    logic [tvtc_pkg::PP_W-1:0]   s2_pl_reg;
    logic [tvtc_pkg::PP_W-1:0]   s2_ph_reg;
    logic [tvtc_pkg::USEC_W-1:0] s2_u_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
        if (en) begin
            s2_neg_reg <= s1_neg_reg;
            s2_big_reg <= big_next;
            s2_pl_reg  <= pl_next;
            s2_ph_reg  <= ph_next;
            s2_u_reg   <= s1_u_reg;
        end
    end

    // ---------------- stage 3: low sum plus ceiling bias ----------------
    logic [tvtc_pkg::PP_W:0] lo_next;

    assign lo_next = {1'b0, s2_pl_reg} +
                     {{(tvtc_pkg::PP_W+1-tvtc_pkg::USEC_W){1'b0}}, s2_u_reg} +
                     {{(tvtc_pkg::PP_W+1-tvtc_pkg::CFG_W){1'b0}}, tk_m1};

    logic                      s3_vld_reg;
    logic                      s3_neg_reg;
    logic                      s3_big_reg;
    logic [tvtc_pkg::PP_W:0]   s3_lo_reg;
    logic [tvtc_pkg::PP_W-1:0] s3_ph_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (en) begin
            s3_vld_reg <= s2_vld_reg;
        end
        if (en) begin
            s3_neg_reg <= s2_neg_reg;
            s3_big_reg <= s2_big_reg;
            s3_lo_reg  <= lo_next;
            s3_ph_reg  <= s2_ph_reg;
        end
    end

    // ---------------- stage 4: full dividend ----------------
    logic [tvtc_pkg::NUM_W-1:0] num_next;

    assign num_next = {s3_ph_reg, {tvtc_pkg::HALF_W{1'b0}}} +
                      {{(tvtc_pkg::NUM_W-tvtc_pkg::PP_W-1){1'b0}}, s3_lo_reg};

    tvtc_pkg::tvtc_flags_t      s4_flags_reg;
    logic [tvtc_pkg::NUM_W-1:0] s4_num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_flags_reg.valid <= 1'b0;
        end else if (en) begin
            s4_flags_reg.valid <= s3_vld_reg;
        end
        if (en) begin
            s4_flags_reg.neg <= s3_neg_reg;
            s4_flags_reg.sat <= s3_big_reg;
            s4_num_reg       <= num_next;
        end
    end

    // ---------------- divider and output register ----------------
    tvtc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .tick_len  (tk_eff),
        .in_flags  (s4_flags_reg),
        .num       (s4_num_reg),
        .out_valid (div_valid),
        .out_ticks (div_ticks)
    );

`ifndef NO_ASSERTIONS
    // a result is never zero
    a_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (div_ticks != '0))
        else $error("zero tick count delivered");

    // input side backs off exactly when the output is blocked
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready inconsistent with output stall");

    // an untaken result is held
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output changed while stalled");
`endif

endmodule
`default_nettype wire

[tb/sv/tb_time_interval_to_tick_count.sv]
`timescale 1ns / 100ps
`default_nettype none

// Expected tick counts, oldest first; checks m_ beats against them.
class tick_scoreboard;
    logic [30:0] tick_q[$];
    int          errors;

    function void note_interval(logic [30:0] expected_ticks);
        tick_q.push_back(expected_ticks);
    endfunction

    // one line per mismatch, and count it
    task report(string msg);
        $display("%s", msg);
        errors++;
    endtask

    task check_ticks(logic [31:0] beat);
        logic [30:0] exp_ticks;
        if (tick_q.size() == 0) begin
            report($sformatf("unexpected m_ beat: tdata=%h", beat));
        end else begin
            exp_ticks = tick_q.pop_front();
            if (beat[30:0] !== exp_ticks || beat[31] !== 1'b0) begin
                report($sformatf("tick_count mismatch: got %0d exp %0d (tdata=%h)",
                                 beat[30:0], exp_ticks, beat));
            end
        end
    endtask
endclass

module tb_time_interval_to_tick_count;

    localparam int LATENCY   = 37;
    localparam int CYCLE_CAP = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;    // [63:0] seconds, [84:64] microseconds, rest zero
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [30:0] tick_count, [31] zero
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tick_scoreboard sb;

    // local copy of the two registers, as the block sees them
    logic [19:0] cfg_tick_len;
    logic [19:0] cfg_tick_rate;
    int          cycle_count;
    int          stall_mode;

    time_interval_to_tick_count u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Predicted tick count for one interval under the current settings.
    function automatic logic [30:0] predict_ticks(logic signed [63:0] sec_in,
                                                   logic signed [20:0] usec_in);
        logic signed [64:0] sec;     // one extra bit makes the borrow exact
        logic signed [63:0] usec;
        logic [63:0]        tk, hz, u, ticks;
        logic [63:0]        max_s64;
        max_s64 = 64'h7FFF_FFFF_FFFF_FFFF;
        sec  = 65'(sec_in);
        usec = 64'(usec_in);
        tk   = (cfg_tick_len == 0) ? 64'd1 : 64'(cfg_tick_len);
        hz   = (cfg_tick_rate == 0) ? 64'd1 : 64'(cfg_tick_rate);
        if (usec < 0) begin
            sec  = sec - 65'sd1;
            usec = usec + 64'sd1000000;
        end
        u = (usec < 0) ? 64'd0 : 64'(usec);
        if (sec < 0)
            ticks = 64'd1;
        else if (sec <= max_s64 / 1000000)
            ticks = (64'(sec) * 1000000 + u + (tk - 1)) / tk + 1;
        else if (sec <= max_s64 / hz)
            ticks = 64'(sec) * hz + (u + (tk - 1)) / tk + 1;
        else
            ticks = max_s64;
        if (ticks > 64'h7FFF_FFFF)
            ticks = 64'h7FFF_FFFF;
        return ticks[30:0];
    endfunction

    // APB write: setup then access, register lands on the access edge.
    task automatic write_reg(tvtc_pkg::reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * int'(idx));
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == tvtc_pkg::REG_TICK_LEN)
            cfg_tick_len = value[19:0];
        else
            cfg_tick_rate = value[19:0];
    endtask

    // One s_ beat; holds tvalid until accepted. The scoreboard learns the
    // interval on the accepting edge.
    task automatic send_interval(logic signed [63:0] sec, logic signed [20:0] usec);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, usec, sec};
        do @(posedge aclk); while (!s_tready);
        sb.note_interval(predict_ticks(sec, usec));
    endtask

    task automatic idle_sender(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // wait until every expected beat has arrived, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.tick_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    // Random seconds: mostly modest values, with spans around the
    // conversion thresholds and the full 64-bit range.
    function automatic logic signed [63:0] rand_seconds();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0: v = 64'($urandom_range(0, 3));
            1: v = 64'($urandom_range(0, 100000));
            2: v = 64'd9223372036854 + $urandom_range(0, 6) - 3;
            3: v = -64'(int'($urandom_range(0, 3)));
            4: v = {$urandom, $urandom};
            5: v = {32'h0, $urandom} << $urandom_range(0, 32);
            6: v = (64'h7FFF_FFFF_FFFF_FFFF / ($urandom_range(1, 1000000)))
                   + $urandom_range(0, 2) - 1;
            default: v = 64'($urandom_range(0, 2200));
        endcase
        return v;
    endfunction

    function automatic logic signed [20:0] rand_usec();
        logic [20:0] v;
        case ($urandom_range(0, 5))
            0: v = 21'($urandom_range(0, 999999));
            1: v = -21'($urandom_range(0, 999999));
            2: v = 21'($urandom);                 // any bit pattern
            3: v = 21'($urandom_range(0, 3));
            default: v = 21'($urandom_range(0, 999999));
        endcase
        return v;
    endfunction

    // receiver: stall pattern of its own, with stretches of no stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= cycle_count[2];
                default: m_tready <= ($urandom_range(0, 1) != 0);
            endcase
            if (m_tvalid && m_tready)
                sb.check_ticks(m_tdata);
        end
    end

    // cycle limit: generous against the slowest correct run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("[time_interval_to_tick_count] ERROR");
            $finish;
        end
    end

    initial begin
        logic [19:0] len_set[6];
        logic [19:0] rate_set[6];
        sb            = new();
        cycle_count   = 0;
        stall_mode    = 0;
        cfg_tick_len  = tvtc_pkg::TICK_LEN_RESET;
        cfg_tick_rate = tvtc_pkg::TICK_RATE_RESET;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, extremes and the named corner cases
        send_interval(64'sh7FFF_FFFF_FFFF_FFFF, 21'sd999999);
        send_interval(64'sh8000_0000_0000_0000, -21'sd1);   // borrow from most negative
        send_interval(64'sh8000_0000_0000_0000, 21'sd0);
        send_interval(64'sd0, 21'sd0);
        send_interval(64'sd0, 21'sd1);
        send_interval(64'sd0, -21'sd1);
        send_interval(64'sd1, -21'sd1);
        send_interval(64'sd1, -21'sd1000000);               // borrow leaves exactly zero microseconds
        send_interval(64'sd5, 21'sh100000);                 // most negative usec
        send_interval(64'sd2, 21'sd1048575);                // usec past one second
        send_interval(-64'sd1, 21'sd999999);
        send_interval(64'sd9223372036854, 21'sd999999);
        send_interval(64'sd9223372036855, 21'sd0);
        send_interval(64'sd2147483, 21'sd647000);
        send_interval(64'sd2147484, 21'sd0);
        drain();

        // settings sweep: zeros act as one, extremes, mid values
        len_set  = '{20'd0, 20'd1, 20'hFFFFF, 20'd1000000, 20'd7, 20'd1000};
        rate_set = '{20'd0, 20'hFFFFF, 20'd1, 20'd1000000, 20'd333, 20'd100};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(tvtc_pkg::REG_TICK_LEN, {12'hFFF, len_set[ph]});  // upper bits ignored
            write_reg(tvtc_pkg::REG_TICK_RATE,
                      ({$urandom} & 32'hFFF0_0000) | {12'h000, rate_set[ph]});
            send_interval(64'sd9223372036855, 21'sd1);
            send_interval(64'sd0, 21'sd999999);
            for (int n = 0; n < 170; ) begin
                int burst;
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < 170; b++, n++)
                    send_interval(rand_seconds(), rand_usec());
                if ($urandom_range(0, 3) != 0)
                    idle_sender($urandom_range(1, 12));
            end
            drain();
        end

        if (sb.errors == 0)
            $display("[time_interval_to_tick_count] OK");
        else
            $display("[time_interval_to_tick_count] ERROR");
        $finish;
    end
endmodule

`default_nettype wire
